// ===== hw/rtl/mbrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrc_pkg
// Types and constants for the Modbus TCP Read Coils framer.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  localparam int unsigned MAX_COILS_DEF = 2000;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QTY_W      = 11;
  localparam int unsigned POS_W      = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_TRANSACTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATION     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COIL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTITY    = 2'd3;

  localparam logic       ACT_REQUEST  = 1'b0;
  localparam logic       ACT_RESPONSE = 1'b1;
  localparam logic       KIND_TX      = 1'b0;
  localparam logic       KIND_RX      = 1'b1;

  localparam logic [7:0] FUNC_READ_COILS = 8'h01;
  localparam logic [7:0] MBAP_LENGTH     = 8'h06;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [3:0] FRAME_LAST      = 4'd11;
  localparam logic [POS_W-1:0] POS_MAX   = 9'd511;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       rx_final;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [7:0] coil_bits;
    logic [3:0] coil_valid;
    logic       bad_response;
    logic       run_end;
  } out_t;

endpackage

// ===== hw/rtl/modbus_read_coils_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_read_coils_framer
// Builds Modbus TCP Read Coils requests and unpacks the response PDU.
// ----------------------------------------------------------------------------
// A request transaction yields twelve frame bytes in consecutive output
// transactions; the input is held off during that burst. A response byte yields
// at most one output transaction (coil group and/or status), so response bytes
// stream at one per clock while the output keeps pace. The single output
// register sets this rate.
module modbus_read_coils_framer
  import mbrc_pkg::*;
#(
  parameter int unsigned MAX_COILS = MAX_COILS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  localparam logic [QTY_W-1:0] QTY_MAX = QTY_W'(MAX_COILS);

  logic [15:0]      trans_r;
  logic [7:0]       station_r;
  logic [15:0]      first_r;
  logic [QTY_W-1:0] qty_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       decl_r, decl_nxt;
  logic             code_ok_r, code_ok_nxt;
  logic [QTY_W-1:0] left_r, left_nxt;

  logic             busy_r, busy_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic             ld_ok, in_acc;
  logic [QTY_W-1:0] eff_qty;
  logic [7:0]       expected;
  logic [3:0]       frame_sel;
  logic [7:0]       frame_byte;
  logic [3:0]       n_coils;
  logic [7:0]       coil_mask;
  logic             is_data, emit_rx, bad;
  out_t             rx_res;

  assign ld_ok    = !out_valid_r || out_ready;
  assign in_ready = !busy_r && ld_ok;
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign eff_qty  = (qty_r > QTY_MAX) ? QTY_MAX : qty_r;
  assign expected = 8'((12'(eff_qty) + 12'd7) >> 3);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r   <= '0;
      station_r <= '0;
      first_r   <= '0;
      qty_r     <= QTY_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRANSACTION: trans_r   <= cfg_wdata;
        CFG_STATION:     station_r <= cfg_wdata[7:0];
        CFG_FIRST_COIL:  first_r   <= cfg_wdata;
        CFG_QUANTITY:    qty_r     <= cfg_wdata[QTY_W-1:0];
        default:         ;
      endcase
    end
  end

  // request frame byte
  assign frame_sel = busy_r ? idx_r : 4'd0;

  always_comb begin
    case (frame_sel)
      4'd0:    frame_byte = trans_r[15:8];
      4'd1:    frame_byte = trans_r[7:0];
      4'd5:    frame_byte = MBAP_LENGTH;
      4'd6:    frame_byte = station_r;
      4'd7:    frame_byte = FUNC_READ_COILS;
      4'd8:    frame_byte = first_r[15:8];
      4'd9:    frame_byte = first_r[7:0];
      4'd10:   frame_byte = 8'(eff_qty >> 8);
      4'd11:   frame_byte = eff_qty[7:0];
      default: frame_byte = 8'h00;
    endcase
  end

  // response byte
  assign is_data   = (pos_r >= POS_W'(2));
  assign n_coils   = (left_r > QTY_W'(BITS_PER_BYTE)) ? BITS_PER_BYTE : left_r[3:0];
  assign coil_mask = ~(8'hFF << n_coils);
  assign emit_rx   = is_data || in_data.rx_final;

  always_comb begin
    code_ok_nxt = code_ok_r;
    decl_nxt    = decl_r;
    left_nxt    = left_r;
    pos_nxt     = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;
    if (pos_r == '0) begin
      code_ok_nxt = (in_data.rx_byte == FUNC_READ_COILS);
      left_nxt    = eff_qty;
    end else if (pos_r == POS_W'(1)) begin
      decl_nxt = in_data.rx_byte;
    end else begin
      left_nxt = left_r - QTY_W'(n_coils);
    end
  end

  assign bad = (pos_nxt < POS_W'(2)) || !code_ok_nxt ||
               (10'(pos_nxt) != 10'(decl_nxt) + 10'd2) || (decl_nxt != expected);

  always_comb begin
    rx_res              = '0;
    rx_res.kind         = KIND_RX;
    rx_res.run_end      = in_data.rx_final;
    rx_res.bad_response = in_data.rx_final && bad;
    if (is_data) begin
      rx_res.coil_bits  = in_data.rx_byte & coil_mask;
      rx_res.coil_valid = n_coils;
    end
  end

  // output register and burst sequencing
  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (ld_ok) begin
      if (busy_r) begin
        out_valid_nxt   = 1'b1;
        out_nxt         = '0;
        out_nxt.kind    = KIND_TX;
        out_nxt.tx_byte = frame_byte;
        out_nxt.run_end = (idx_r == FRAME_LAST);
        idx_nxt         = idx_r + 4'd1;
        if (idx_r == FRAME_LAST) begin
          busy_nxt = 1'b0;
        end
      end else if (in_acc) begin
        if (in_data.action == ACT_REQUEST) begin
          out_valid_nxt   = 1'b1;
          out_nxt         = '0;
          out_nxt.kind    = KIND_TX;
          out_nxt.tx_byte = frame_byte;
          busy_nxt        = 1'b1;
          idx_nxt         = 4'd1;
        end else if (emit_rx) begin
          out_valid_nxt = 1'b1;
          out_nxt       = rx_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      decl_r      <= '0;
      code_ok_r   <= 1'b1;
      left_r      <= '0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        if (in_data.action == ACT_REQUEST || in_data.rx_final) begin
          pos_r     <= '0;
          decl_r    <= '0;
          code_ok_r <= 1'b1;
          left_r    <= '0;
        end else begin
          pos_r     <= pos_nxt;
          decl_r    <= decl_nxt;
          code_ok_r <= code_ok_nxt;
          left_r    <= left_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // checks
  a_burst_idx: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r >= 4'd1 && idx_r <= FRAME_LAST))
    else $error("frame index out of range during burst");

  a_req_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_REQUEST) |=>
      (out_valid_r && out_r.kind == KIND_TX && out_r.tx_byte == trans_r[15:8] && busy_r))
    else $error("request did not start frame burst");

  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && out_r.kind == KIND_TX && out_r.run_end) |-> !busy_r)
    else $error("frame burst still running after last byte");

  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.action == ACT_RESPONSE && in_data.rx_final) |=>
      (pos_r == '0 && left_r == '0 && code_ok_r))
    else $error("response state not cleared after final byte");

  a_coil_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_RX) |->
      (out_r.coil_valid <= BITS_PER_BYTE && (out_r.coil_bits >> out_r.coil_valid) == 8'h00))
    else $error("coil group carries bits beyond its valid count");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Modbus TCP Read Coils framer. Request frames and
// response PDU bytes are queued per phase and driven over valid/ready with
// random gaps on both sides. A behavioural model tracks the configuration and
// the response state and predicts every output transaction, which is compared
// field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mbrc_pkg::*;

  typedef enum int {
    REPLY_GOOD,
    REPLY_BAD_FUNC,
    REPLY_BAD_COUNT,
    REPLY_SHORT,
    REPLY_LONG,
    REPLY_CUT_AT_CODE,
    REPLY_CUT_AT_COUNT,
    REPLY_ABANDONED
  } reply_shape_e;

  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_ITEMS     = 150;
  localparam int PHASE_ITEMS      = 30;
  localparam int LONG_REPLY_BYTES = 12;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;

  // register shadows
  logic [15:0]      tid_reg        = '0;
  logic [7:0]       unit_reg       = '0;
  logic [15:0]      start_addr_reg = '0;
  logic [QTY_W-1:0] qty_reg        = 11'd1;

  // response tracking
  logic [POS_W-1:0] rsp_count    = '0;
  logic [7:0]       count_field  = '0;
  logic             func_matched = 1'b1;
  logic [QTY_W-1:0] coils_owed   = '0;

  in_t  stim_q[$];
  out_t coil_frame_q[$];

  int   in_gap = 0;
  int   out_gap = 0;
  int   hold_left = 0;
  logic steady_flow = 1'b0;
  logic start_long_hold = 1'b0;
  logic long_hold_used = 1'b0;

  int mismatches = 0;
  int items_taken = 0;
  int items_queued = 0;
  int results_seen = 0;
  int frames_sent = 0;
  int replies_closed = 0;

  modbus_read_coils_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [QTY_W-1:0] granted_qty();
    return (qty_reg > QTY_W'(MAX_COILS_DEF)) ? QTY_W'(MAX_COILS_DEF) : qty_reg;
  endfunction

  function automatic void forget_reply();
    rsp_count    = '0;
    count_field  = '0;
    func_matched = 1'b1;
    coils_owed   = '0;
  endfunction

  function automatic void frame_or_unpack(input in_t it);
    out_t             r;
    logic [7:0]       frame [12];
    logic [QTY_W-1:0] q;
    logic [3:0]       n;
    logic [8:0]       mask;
    logic [POS_W-1:0] pos;
    int               need;
    r = '0;
    if (it.action == ACT_REQUEST) begin
      q = granted_qty();
      frame = '{tid_reg[15:8], tid_reg[7:0], 8'h00, 8'h00, 8'h00, MBAP_LENGTH, unit_reg,
                FUNC_READ_COILS, start_addr_reg[15:8], start_addr_reg[7:0],
                {5'b0, q[10:8]}, q[7:0]};
      for (int k = 0; k < 12; k++) begin
        r.kind    = KIND_TX;
        r.tx_byte = frame[k];
        r.run_end = (k == int'(FRAME_LAST));
        coil_frame_q.insert(coil_frame_q.size(), r);
      end
      frames_sent++;
      forget_reply();
    end else begin
      pos    = rsp_count;
      r.kind = KIND_RX;
      if (pos == 0) begin
        func_matched = (it.rx_byte == FUNC_READ_COILS);
        coils_owed   = granted_qty();
      end else if (pos == 1) begin
        count_field = it.rx_byte;
      end else begin
        n            = (coils_owed > QTY_W'(BITS_PER_BYTE)) ? BITS_PER_BYTE : coils_owed[3:0];
        mask         = (9'd1 << n) - 9'd1;
        r.coil_valid = n;
        r.coil_bits  = it.rx_byte & mask[7:0];
        coils_owed   = coils_owed - QTY_W'(n);
      end
      if (pos < POS_MAX) rsp_count = pos + POS_W'(1);
      if (it.rx_final) begin
        need = (int'(granted_qty()) + 7) / 8;
        r.bad_response = (rsp_count < 2) || !func_matched ||
                         (int'(rsp_count) != int'(count_field) + 2) ||
                         (int'(count_field) != need);
        r.run_end = 1'b1;
        coil_frame_q.insert(coil_frame_q.size(), r);
        replies_closed++;
        forget_reply();
      end else if (pos >= 2) begin
        coil_frame_q.insert(coil_frame_q.size(), r);
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void offer(input logic act, input logic [7:0] b, input logic last);
    in_t it;
    it.action   = act;
    it.rx_byte  = b;
    it.rx_final = last;
    stim_q.insert(stim_q.size(), it);
    items_queued++;
  endfunction

  function automatic void offer_request();
    offer(ACT_REQUEST, 8'($urandom), 1'($urandom));
  endfunction

  function automatic void offer_reply(input reply_shape_e shape);
    int         data_len;
    int         total;
    int         count;
    logic [7:0] code;
    data_len = (int'(granted_qty()) + 7) / 8;
    count    = data_len;
    code     = FUNC_READ_COILS;
    case (shape)
      REPLY_BAD_FUNC:  code = FUNC_READ_COILS ^ 8'($urandom_range(1, 255));
      REPLY_BAD_COUNT: begin
        count    = data_len + 1;
        data_len = count;
      end
      REPLY_SHORT: begin
        if (data_len > 0) data_len = data_len - 1;
        else count = 1;
      end
      REPLY_LONG: data_len = data_len + $urandom_range(1, 3);
      default: ;
    endcase
    total = 2 + data_len;
    if (shape == REPLY_CUT_AT_CODE) total = 1;
    else if (shape == REPLY_CUT_AT_COUNT) total = 2;
    else if (shape == REPLY_ABANDONED) total = $urandom_range(1, total);
    for (int i = 0; i < total; i++) begin
      logic [7:0] b;
      b = (i == 0) ? code : (i == 1) ? 8'(count) : 8'($urandom);
      offer(ACT_RESPONSE, b, (i == total - 1) && (shape != REPLY_ABANDONED));
    end
    // a request cuts the partial response short
    if (shape == REPLY_ABANDONED) offer_request();
  endfunction

  function automatic logic [QTY_W-1:0] pick_qty();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return QTY_W'($urandom_range(1, 8));
      2, 3:    return QTY_W'($urandom_range(1, 24));
      default: return QTY_W'($urandom_range(25, 96));
    endcase
  endfunction

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TRANSACTION: tid_reg = val;
      CFG_STATION:     unit_reg = val[7:0];
      CFG_FIRST_COIL:  start_addr_reg = val;
      CFG_QUANTITY:    qty_reg = val[QTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] tid, input logic [7:0] unit,
                               input logic [15:0] addr, input logic [QTY_W-1:0] qty);
    program_reg(CFG_TRANSACTION, tid);
    program_reg(CFG_STATION, {8'h00, unit});
    program_reg(CFG_FIRST_COIL, addr);
    program_reg(CFG_QUANTITY, {5'b0, qty});
  endtask

  // wait for the block to go quiet; header bytes leave no trace, hence the tail
  task automatic settle();
    while (stim_q.size() != 0 || in_valid || coil_frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (stim_q.size() > 0) begin
        in_data  <= stim_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= steady_flow ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      items_taken++;
      frame_or_unpack(in_data);
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_ready      <= 1'b0;
      out_gap        <= 0;
      hold_left      <= 0;
      long_hold_used <= 1'b0;
    end else if (start_long_hold && !long_hold_used) begin
      long_hold_used <= 1'b1;
      hold_left      <= LONG_HOLD_CYCLES;
      out_ready      <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (out_valid && out_ready) begin
      draw = steady_flow ? 0 : $urandom_range(0, 7);
      out_gap   <= draw;
      out_ready <= (draw == 0);
    end else if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= (out_gap == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker

  function automatic string describe(input out_t r);
    return $sformatf("kind=%0d tx=%02h coils=%02h/%0d bad=%0d end=%0d",
                     r.kind, r.tx_byte, r.coil_bits, r.coil_valid, r.bad_response, r.run_end);
  endfunction

  function automatic void report_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (coil_frame_q.size() == 0) begin
        report_error({"unexpected transaction: ", describe(out_data)});
      end else begin
        want = coil_frame_q.pop_front();
        if (out_data.kind !== want.kind || out_data.tx_byte !== want.tx_byte ||
            out_data.coil_bits !== want.coil_bits || out_data.coil_valid !== want.coil_valid ||
            out_data.bad_response !== want.bad_response || out_data.run_end !== want.run_end)
          report_error($sformatf("transaction %0d: expected %s, got %s",
                                 results_seen, describe(want), describe(out_data)));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase;
    int base;
    int chunk;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one coil
    offer(ACT_REQUEST, 8'hFF, 1'b1);
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b0);
    offer(ACT_RESPONSE, 8'h01, 1'b0);
    offer(ACT_RESPONSE, 8'hFF, 1'b1);
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b0);
    offer(ACT_RESPONSE, 8'h01, 1'b0);
    offer(ACT_RESPONSE, 8'hFE, 1'b1);
    offer(ACT_RESPONSE, 8'h81, 1'b0);
    offer(ACT_RESPONSE, 8'h01, 1'b0);
    offer(ACT_RESPONSE, 8'h01, 1'b1);
    // byte count off by one, size consistent; second data byte is surplus
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b0);
    offer(ACT_RESPONSE, 8'h02, 1'b0);
    offer(ACT_RESPONSE, 8'hAA, 1'b0);
    offer(ACT_RESPONSE, 8'h55, 1'b1);
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b1);
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b0);
    offer(ACT_RESPONSE, 8'h01, 1'b1);
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b0);
    offer(ACT_RESPONSE, 8'h01, 1'b0);
    offer(ACT_RESPONSE, 8'hFF, 1'b0);
    offer(ACT_REQUEST, 8'h00, 1'b0);
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b0);
    offer(ACT_RESPONSE, 8'h01, 1'b0);
    offer(ACT_RESPONSE, 8'hFF, 1'b0);
    offer(ACT_RESPONSE, 8'hFF, 1'b1);
    settle();

    // all-ones header fields, quantity above the coil limit
    load_settings(16'hFFFF, 8'hFF, 16'hFFFF, 11'h7FF);
    offer_request();
    offer_reply(REPLY_CUT_AT_COUNT);
    settle();

    // zero everywhere; no data bytes expected
    load_settings(16'h0000, 8'h00, 16'h0000, 11'd0);
    offer_request();
    offer_reply(REPLY_GOOD);
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b0);
    offer(ACT_RESPONSE, 8'h00, 1'b0);
    offer(ACT_RESPONSE, 8'hFF, 1'b1);
    settle();

    // oversized response: surplus data bytes carry no coils
    load_settings(16'h1234, 8'h11, 16'h00FF, 11'd9);
    offer(ACT_RESPONSE, FUNC_READ_COILS, 1'b0);
    offer(ACT_RESPONSE, 8'h02, 1'b0);
    for (int i = 0; i < LONG_REPLY_BYTES; i++)
      offer(ACT_RESPONSE, 8'($urandom), i == LONG_REPLY_BYTES - 1);
    settle();

    phase = 0;
    base  = items_queued;
    while (items_queued - base < RANDOM_ITEMS) begin
      load_settings(16'($urandom), 8'($urandom), 16'($urandom), pick_qty());
      steady_flow <= (phase % 3 == 2);
      chunk = items_queued + PHASE_ITEMS;
      while (items_queued < chunk) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            offer_request();
            offer_reply(REPLY_GOOD);
          end
          6:       offer_reply(REPLY_GOOD);
          7, 8:    offer_reply(reply_shape_e'($urandom_range(1, 7)));
          default: repeat ($urandom_range(1, 4)) offer(1'($urandom), 8'($urandom), 1'($urandom));
        endcase
      end
      // in the first phase the receiver backs off while a full phase is queued so the block backs up
      if (phase == 0) start_long_hold <= 1'b1;
      settle();
      phase++;
    end

    // request at the coil limit, answer cut after the byte count
    load_settings(16'($urandom), 8'($urandom), 16'($urandom), QTY_W'(MAX_COILS_DEF));
    steady_flow <= 1'b0;
    offer_request();
    offer_reply(REPLY_CUT_AT_COUNT);
    settle();

    $display("Covered %0d input transactions (%0d requests, %0d responses closed), %0d results.",
             items_taken, frames_sent, replies_closed, results_seen);
    $display("Settings: reset values, field extremes, zero and saturated quantity, %0d random.",
             phase);
    if (mismatches == 0 && coil_frame_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", coil_frame_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mbrc_pkg.sv
hw/rtl/modbus_read_coils_framer.sv
dv/tb_top.sv
